>>> hdl/ccbf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the content column bounds finder.
// No dependencies; imported by every module of the block.
package ccbf_pkg;

    localparam int MAX_COLUMNS = 32768;
    localparam int COL_W       = 15;
    localparam int FIELD_MAX   = (1 << COL_W) - 1;
    localparam int COL_LIMIT_I = (MAX_COLUMNS - 1 < FIELD_MAX) ? MAX_COLUMNS - 1 : FIELD_MAX;

    typedef logic [COL_W-1:0] t_col;

    localparam t_col COL_LIMIT = t_col'(COL_LIMIT_I);

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 15;
    localparam int CFG_IDX_W = 3;

    typedef logic [PIX_W-1:0] t_pix;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIXED_L   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIXED_R   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_WIDTH = 3'd4;

    localparam logic RST_ENABLE    = 1'b1;
    localparam t_pix RST_THRESHOLD = 8'd250;
    localparam t_col RST_FIXED_L   = 15'd208;
    localparam t_col RST_FIXED_R   = 15'd30895;
    localparam t_col RST_MIN_WIDTH = 15'd10;

    typedef struct packed {
        logic column_check_enable;
        t_pix white_threshold;
        t_col fixed_left;
        t_col fixed_right;
        t_col min_width;
    } t_cfg;

    typedef struct packed {
        t_col left;
        t_col right;
    } t_span;

endpackage

>>> hdl/ccbf_scan.sv
`timescale 1ns / 1ps
// Pixel scan: per-row dark span tracking, frame bound merging and the
// frame-end bounds register. Depends on ccbf_pkg.
module ccbf_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ccbf_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  ccbf_pkg::t_pix  i_pixel,
    input  logic            i_row_end,
    input  logic            i_frame_end,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output ccbf_pkg::t_span o_res
);
    import ccbf_pkg::*;

    t_col  r_col, n_col;
    t_col  r_row_first, n_row_first;
    t_col  r_row_last, n_row_last;
    logic  r_row_dark, n_row_dark;
    logic  r_row_nz, n_row_nz;
    t_col  r_bnd_first, n_bnd_first;
    t_col  r_bnd_last, n_bnd_last;
    logic  r_bnd_flag, n_bnd_flag;
    logic  r_pending, n_pending;
    logic  r_res_valid, n_res_valid;
    t_span r_res, n_res;

    logic  w_accept, w_dark, w_end;
    logic  w_rdark, w_rnz, w_black_fill;
    t_col  w_rfirst, w_rlast;
    t_col  w_mfirst, w_mlast;
    logic  w_mflag;

    assign o_ready     = !r_res_valid || i_res_ready;
    assign w_accept    = i_valid && o_ready;
    assign w_dark      = i_pixel < i_cfg.white_threshold;
    assign w_end       = i_row_end || i_frame_end;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        // row span including this pixel
        w_rdark  = r_row_dark || w_dark;
        w_rnz    = r_row_nz || (i_pixel != '0);
        w_rfirst = r_row_dark ? r_row_first : r_col;
        w_rlast  = w_dark ? r_col : r_row_last;
        // pending black rows turn columns 0..col dark when a content row ends
        w_black_fill = w_rnz && r_pending && (i_cfg.white_threshold != '0);

        w_mfirst = r_bnd_first;
        w_mlast  = r_bnd_last;
        w_mflag  = r_bnd_flag;
        if (w_black_fill) begin
            w_mfirst = '0;
            w_mlast  = (r_bnd_flag && r_bnd_last > r_col) ? r_bnd_last : r_col;
            w_mflag  = 1'b1;
        end else if (w_rnz && w_rdark) begin
            w_mfirst = (r_bnd_flag && r_bnd_first < w_rfirst) ? r_bnd_first : w_rfirst;
            w_mlast  = (r_bnd_flag && r_bnd_last > w_rlast) ? r_bnd_last : w_rlast;
            w_mflag  = 1'b1;
        end
    end

    always_comb begin
        n_col       = r_col;
        n_row_first = r_row_first;
        n_row_last  = r_row_last;
        n_row_dark  = r_row_dark;
        n_row_nz    = r_row_nz;
        n_bnd_first = r_bnd_first;
        n_bnd_last  = r_bnd_last;
        n_bnd_flag  = r_bnd_flag;
        n_pending   = r_pending;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;

        if (w_accept) begin
            if (!w_end) begin
                n_row_first = w_rfirst;
                n_row_last  = w_rlast;
                n_row_dark  = w_rdark;
                n_row_nz    = w_rnz;
                if (r_col < COL_LIMIT) begin
                    n_col = r_col + t_col'(1);
                end
            end else begin
                n_col       = '0;
                n_row_first = '0;
                n_row_last  = '0;
                n_row_dark  = 1'b0;
                n_row_nz    = 1'b0;
                n_bnd_first = w_mfirst;
                n_bnd_last  = w_mlast;
                n_bnd_flag  = w_mflag;
                n_pending   = !w_rnz;
                if (i_frame_end) begin
                    // trailing black rows are dropped with the frame state
                    n_bnd_first = '0;
                    n_bnd_last  = '0;
                    n_bnd_flag  = 1'b0;
                    n_pending   = 1'b0;
                    n_res_valid = 1'b1;
                    if (!i_cfg.column_check_enable) begin
                        n_res.left  = i_cfg.fixed_left;
                        n_res.right = i_cfg.fixed_right;
                    end else if (w_mflag) begin
                        n_res.left  = w_mfirst;
                        n_res.right = w_mlast;
                    end else begin
                        n_res.left  = '0;
                        n_res.right = r_col;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row_first <= '0;
            r_row_last  <= '0;
            r_row_dark  <= 1'b0;
            r_row_nz    <= 1'b0;
            r_bnd_first <= '0;
            r_bnd_last  <= '0;
            r_bnd_flag  <= 1'b0;
            r_pending   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row_first <= n_row_first;
            r_row_last  <= n_row_last;
            r_row_dark  <= n_row_dark;
            r_row_nz    <= n_row_nz;
            r_bnd_first <= n_bnd_first;
            r_bnd_last  <= n_bnd_last;
            r_bnd_flag  <= n_bnd_flag;
            r_pending   <= n_pending;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

>>> hdl/ccbf_result.sv
`timescale 1ns / 1ps
// Result stage: width check against the minimum and the output register.
// Depends on ccbf_pkg.
module ccbf_result (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_res_valid,
    output logic            o_res_ready,
    input  ccbf_pkg::t_span i_res,
    input  ccbf_pkg::t_col  i_min_width,
    output logic            o_valid,
    input  logic            i_ready,
    output ccbf_pkg::t_span o_span,
    output logic            o_crop_valid
);
    import ccbf_pkg::*;

    logic  r_valid, n_valid;
    t_span r_span, n_span;
    logic  r_crop_valid, n_crop_valid;
    logic  [COL_W:0] w_limit;

    assign o_res_ready  = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_span       = r_span;
    assign o_crop_valid = r_crop_valid;
    assign w_limit      = {1'b0, i_res.left} + {1'b0, i_min_width};

    always_comb begin
        n_valid      = r_valid && !i_ready;
        n_span       = r_span;
        n_crop_valid = r_crop_valid;
        if (i_res_valid && o_res_ready) begin
            n_valid      = 1'b1;
            n_span       = i_res;
            n_crop_valid = {1'b0, i_res.right} > w_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_span       <= n_span;
        r_crop_valid <= n_crop_valid;
    end

endmodule

>>> hdl/content_column_bounds_finder.sv
`timescale 1ns / 1ps
// Top level of the content column bounds finder: configuration registers,
// pixel scan and result stage. Depends on ccbf_pkg, ccbf_scan, ccbf_result.
//
//  channel   direction  tdata                               tuser
//  s_axis    in         [7:0] pixel, tlast = row end         [0] frame end
//  m_axis    out        [14:0] crop_left, [29:15] crop_right [0] crop valid
//  i_cfg_*   in         write enable, index, 15-bit data     -
//
// One pixel transfer per cycle, sustained while s_axis_tready is high. A frame-end
// pixel yields one result, held first in the scan bounds register and then,
// after the width check, in the output register.
// Reset (synchronous, active low) clears frame state and loads register defaults.
// A stall on m_axis holds the output register; s_axis keeps taking pixels
// until both result registers are full.
module content_column_bounds_finder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel
    input  logic                            s_axis_tlast,   // row end
    input  logic [0:0]                      s_axis_tuser,   // [0] frame end
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,   // [14:0] left, [29:15] right
    output logic [0:0]                      m_axis_tuser,   // [0] crop valid
    input  logic                            i_cfg_we,
    input  logic [ccbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ccbf_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import ccbf_pkg::*;

    t_cfg  r_cfg, n_cfg;
    logic  w_res_valid, w_res_ready, w_crop_valid;
    t_span w_res, w_out;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_ENABLE:    n_cfg.column_check_enable = i_cfg_wdata[0];
                CFG_IDX_THRESHOLD: n_cfg.white_threshold     = i_cfg_wdata[PIX_W-1:0];
                CFG_IDX_FIXED_L:   n_cfg.fixed_left          = i_cfg_wdata[COL_W-1:0];
                CFG_IDX_FIXED_R:   n_cfg.fixed_right         = i_cfg_wdata[COL_W-1:0];
                CFG_IDX_MIN_WIDTH: n_cfg.min_width           = i_cfg_wdata[COL_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_check_enable <= RST_ENABLE;
            r_cfg.white_threshold     <= RST_THRESHOLD;
            r_cfg.fixed_left          <= RST_FIXED_L;
            r_cfg.fixed_right         <= RST_FIXED_R;
            r_cfg.min_width           <= RST_MIN_WIDTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ccbf_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_pixel     (s_axis_tdata),
        .i_row_end   (s_axis_tlast),
        .i_frame_end (s_axis_tuser[0]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    ccbf_result u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (w_res_valid),
        .o_res_ready  (w_res_ready),
        .i_res        (w_res),
        .i_min_width  (r_cfg.min_width),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_span       (w_out),
        .o_crop_valid (w_crop_valid)
    );

    assign m_axis_tdata = {2'b00, w_out.right, w_out.left};
    assign m_axis_tuser = w_crop_valid;

endmodule
